// ----- hdl/bpa_pkg.sv -----
// Package for the bitmap page allocator: sizes, request codes, shared types
// and bit-search helpers. No dependencies.
package bpa_pkg;

  localparam int NumPages  = 65536;
  localparam int WordBits  = 64;
  localparam int MapWords  = NumPages / WordBits;
  localparam int WordIdxW  = $clog2(MapWords);
  localparam int BitIdxW   = $clog2(WordBits);
  localparam int PageW     = 16;
  localparam int CntW      = 17;
  localparam logic [CntW-1:0] CntMax   = '1;
  localparam logic [CntW-1:0] PagesLim = CntW'(NumPages);

  // request kinds as they arrive on the input word
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RUN   = 2'd1,
    OP_FREE  = 2'd2,
    OP_RESV  = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [PageW-1:0] target;
    logic [CntW-1:0]  len;
  } req_t;

  // back-end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } ctl_t;

  // index of lowest set bit, WordBits when none
  function automatic logic [BitIdxW:0] low_one(logic [WordBits-1:0] v);
    logic [BitIdxW:0] r;
    r = (BitIdxW+1)'(WordBits);
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) r = (BitIdxW+1)'(i);
    end
    return r;
  endfunction

  // number of consecutive ones from the top bit down
  function automatic logic [BitIdxW:0] top_ones(logic [WordBits-1:0] v);
    logic [BitIdxW:0] h;
    logic             f;
    h = '0;
    f = 1'b0;
    for (int i = 0; i < WordBits; i++) begin
      if (!v[i]) begin
        h = (BitIdxW+1)'(i);
        f = 1'b1;
      end
    end
    return f ? (BitIdxW+1)'(WordBits - 1) - h : (BitIdxW+1)'(WordBits);
  endfunction

endpackage

// ----- hdl/bpa_front.sv -----
// Front end: two-entry request queue, decodes the kind into a request code.
// Depends on bpa_pkg.
module bpa_front import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [PageW-1:0] target_page_i,
  input  logic [CntW-1:0]  run_length_i,
  input  ctl_t             ctl_i,
  output logic             req_valid_o,
  output req_t             req_o
);

  req_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  op_e        op_dec;

  // kind decode
  always_comb begin
    case (kind_i)
      OP_ALLOC: op_dec = OP_ALLOC;
      OP_RUN:   op_dec = OP_RUN;
      OP_FREE:  op_dec = OP_FREE;
      default:  op_dec = OP_RESV;
    endcase
  end

  assign in_stall_o  = fill_q[1] || ctl_i.clearing;
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = fill_q != 2'd0;
  assign req_o       = q_mem[rd_ptr_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= '{op: op_dec, target: target_page_i, len: run_length_i};
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (ctl_i.pop) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, ctl_i.pop};
    end
  end

endmodule

// ----- hdl/bpa_back.sv -----
// Back end: bitmap memory, word-at-a-time scan sequencer, counters and
// the output register. Depends on bpa_pkg.
module bpa_back import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i,
  input  logic             req_valid_i,
  input  req_t             req_i,
  output ctl_t             ctl_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             ok_o,
  output logic [PageW-1:0] first_page_o,
  output logic [CntW-1:0]  used_count_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MEV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [WordBits-1:0] mem [MapWords];
  logic [WordBits-1:0] rdata_q;

  logic [2:0]          state_q, state_d;
  op_e                 op_q, op_d;
  logic [PageW-1:0]    tgt_q, tgt_d;
  logic [CntW-1:0]     len_q, len_d;
  logic [WordIdxW-1:0] w_q, w_d;
  logic [CntW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic                phase_q, phase_d;
  logic [CntW-1:0]     found_q, found_d;
  logic [PageW-1:0]    first_q, first_d;
  logic                rok_q, rok_d;
  logic [PageW-1:0]    rstart_q, rstart_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PageW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]     pt_q;
  logic                ovld_q, ovld_d;
  logic                ook_q, ook_d;
  logic [PageW-1:0]    ostart_q, ostart_d;
  logic [CntW-1:0]     oused_q, oused_d;

  logic                mem_we;
  logic [WordBits-1:0] mem_wd;
  logic [CntW-1:0]     tot;
  logic [WordBits-1:0] win, freem, runs;
  logic [CntW-1:0]     nxt_start;
  logic [BitIdxW:0]    lead, trail, low_free, low_run;
  logic [CntW:0]       carry_sum, cnt_inc, cnt_add;

  // bits of word w whose page lies in [lo, hi)
  function automatic logic [WordBits-1:0] win_mask(logic [WordIdxW-1:0] w,
                                                   logic [CntW-1:0] lo,
                                                   logic [CntW-1:0] hi);
    logic [WordIdxW:0]   wx;
    logic [WordBits-1:0] lm, hm;
    wx = {1'b0, w};
    if (wx > lo[CntW-1:BitIdxW])       lm = '1;
    else if (wx == lo[CntW-1:BitIdxW]) lm = '1 << lo[BitIdxW-1:0];
    else                               lm = '0;
    if (wx < hi[CntW-1:BitIdxW])       hm = '1;
    else if (wx == hi[CntW-1:BitIdxW]) hm = ~('1 << hi[BitIdxW-1:0]);
    else                               hm = '0;
    return lm & hm;
  endfunction

  // start positions of len free bits lying wholly inside the word
  function automatic logic [WordBits-1:0] run_starts(logic [WordBits-1:0] m,
                                                     logic [CntW-1:0] len);
    logic [WordBits-1:0] p, r;
    logic [BitIdxW:0]    off;
    p   = m;
    r   = '1;
    off = '0;
    for (int j = 0; j < BitIdxW; j++) begin
      if (len[j]) begin
        r   = r & (p >> off);
        off = off + (BitIdxW+1)'(1 << j);
      end
      p = p & (p >> (1 << j));
    end
    return (len[CntW-1:BitIdxW] != '0) ? '0 : r;
  endfunction

  // bitmap: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[w_q] <= mem_wd;
    rdata_q <= mem[w_q];
  end

  assign tot       = (pt_q > PagesLim) ? PagesLim : pt_q;
  assign win       = win_mask(w_q, lo_q, hi_q);
  assign freem     = ~rdata_q & win;
  assign runs      = run_starts(freem, len_q);
  assign lead      = low_one(~freem);
  assign trail     = top_ones(freem);
  assign low_free  = low_one(freem);
  assign low_run   = low_one(runs);
  assign nxt_start = {({1'b0, w_q} + 1'b1), {BitIdxW{1'b0}}};
  assign carry_sum = {1'b0, found_q} + (CntW+1)'(lead);
  assign cnt_inc   = {1'b0, cnt_q} + 1'b1;
  assign cnt_add   = {1'b0, cnt_q} + {1'b0, len_q};

  assign ctl_o.pop      = (state_q == S_IDLE) && req_valid_i;
  assign ctl_o.clearing = (state_q == S_CLEAR);

  // sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    tgt_d    = tgt_q;
    len_d    = len_q;
    w_d      = w_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    phase_d  = phase_q;
    found_d  = found_q;
    first_d  = first_q;
    rok_d    = rok_q;
    rstart_d = rstart_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    ovld_d   = ovld_q && out_stall_i;
    ook_d    = ook_q;
    ostart_d = ostart_q;
    oused_d  = oused_q;
    mem_we   = 1'b0;
    mem_wd   = '1;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        w_d    = w_q + 1'b1;
        if (w_q == WordIdxW'(MapWords - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.op;
          tgt_d    = req_i.target;
          len_d    = req_i.len;
          rok_d    = 1'b0;
          rstart_d = '0;
          found_d  = '0;
          first_d  = '0;
          phase_d  = 1'b0;
          state_d  = S_DONE;
          case (req_i.op)
            OP_ALLOC: begin
              if (tot != '0) begin
                state_d = S_RD;
                hi_d    = tot;
                if ({1'b0, cur_q} >= tot) begin
                  phase_d = 1'b1;
                  lo_d    = '0;
                  w_d     = '0;
                end else begin
                  lo_d = {1'b0, cur_q};
                  w_d  = cur_q[PageW-1:BitIdxW];
                end
              end
            end
            OP_RUN: begin
              if (req_i.len != '0 && tot > CntW'(1)) begin
                state_d = S_RD;
                lo_d    = CntW'(1);
                hi_d    = tot;
                w_d     = '0;
              end
            end
            default: begin
              if ({1'b0, req_i.target} < tot) begin
                state_d = S_RD;
                w_d     = req_i.target[PageW-1:BitIdxW];
              end
            end
          endcase
        end
      end

      S_RD: state_d = S_EV;

      S_EV: begin
        state_d = S_DONE;
        case (op_q)
          OP_ALLOC: begin
            if (freem != '0) begin
              mem_we   = 1'b1;
              mem_wd   = rdata_q | (WordBits'(1) << low_free[BitIdxW-1:0]);
              rok_d    = 1'b1;
              rstart_d = {w_q, low_free[BitIdxW-1:0]};
              cur_d    = {w_q, low_free[BitIdxW-1:0]};
              cnt_d    = cnt_inc[CntW] ? CntMax : cnt_inc[CntW-1:0];
            end else if (nxt_start < hi_q) begin
              w_d     = w_q + 1'b1;
              state_d = S_RD;
            end else if (!phase_q && cur_q != '0) begin
              phase_d = 1'b1;
              lo_d    = '0;
              hi_d    = {1'b0, cur_q};
              w_d     = '0;
              state_d = S_RD;
            end
          end
          OP_RUN: begin
            if (carry_sum >= {1'b0, len_q}) begin
              rstart_d = (found_q != '0) ? first_q : {w_q, {BitIdxW{1'b0}}};
              w_d      = (found_q != '0) ? first_q[PageW-1:BitIdxW] : w_q;
              state_d  = S_MRD;
            end else if (lead[BitIdxW]) begin
              if (found_q == '0) first_d = {w_q, {BitIdxW{1'b0}}};
              found_d = found_q + CntW'(WordBits);
              if (nxt_start < hi_q) begin
                w_d     = w_q + 1'b1;
                state_d = S_RD;
              end
            end else if (runs != '0) begin
              rstart_d = {w_q, low_run[BitIdxW-1:0]};
              state_d  = S_MRD;
            end else begin
              found_d = CntW'(trail);
              first_d = {w_q, BitIdxW'((BitIdxW+1)'(WordBits) - trail)};
              if (nxt_start < hi_q) begin
                w_d     = w_q + 1'b1;
                state_d = S_RD;
              end
            end
            if (state_d == S_MRD) begin
              lo_d = {1'b0, rstart_d};
              hi_d = {1'b0, rstart_d} + len_q;
            end
          end
          OP_FREE: begin
            if (rdata_q[tgt_q[BitIdxW-1:0]]) begin
              mem_we   = 1'b1;
              mem_wd   = rdata_q & ~(WordBits'(1) << tgt_q[BitIdxW-1:0]);
              rok_d    = 1'b1;
              rstart_d = tgt_q;
              if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            end
          end
          default: begin
            if (!rdata_q[tgt_q[BitIdxW-1:0]]) begin
              mem_we   = 1'b1;
              mem_wd   = rdata_q | (WordBits'(1) << tgt_q[BitIdxW-1:0]);
              rok_d    = 1'b1;
              rstart_d = tgt_q;
              cnt_d    = cnt_inc[CntW] ? CntMax : cnt_inc[CntW-1:0];
            end
          end
        endcase
      end

      // mark the found run, one word per read/write pair
      S_MRD: state_d = S_MEV;

      S_MEV: begin
        mem_we = 1'b1;
        mem_wd = rdata_q | win;
        if (nxt_start < hi_q) begin
          w_d     = w_q + 1'b1;
          state_d = S_MRD;
        end else begin
          rok_d   = 1'b1;
          cnt_d   = cnt_add[CntW] ? CntMax : cnt_add[CntW-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d   = 1'b1;
          ook_d    = rok_q;
          ostart_d = rok_q ? rstart_q : '0;
          oused_d  = cnt_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) cnt_d = cfg_wdata_i;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      w_q     <= '0;
      cnt_q   <= PagesLim;
      pt_q    <= PagesLim;
      cur_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) pt_q <= cfg_wdata_i;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tgt_q    <= tgt_d;
    len_q    <= len_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    phase_q  <= phase_d;
    found_q  <= found_d;
    first_q  <= first_d;
    rok_q    <= rok_d;
    rstart_q <= rstart_d;
    ook_q    <= ook_d;
    ostart_q <= ostart_d;
    oused_q  <= oused_d;
  end

  assign out_valid_o  = ovld_q;
  assign ok_o         = ook_q;
  assign first_page_o = ostart_q;
  assign used_count_o = oused_q;

endmodule

// ----- hdl/bitmap_page_allocator.sv -----
// Top level of the bitmap page allocator: request queue plus scan engine.
// Depends on bpa_pkg, bpa_front, bpa_back.
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid_i / in_stall_o | kind, target_page, run_length
//  out     | output    | out_valid_o/out_stall_i | ok, first_page, used_count
//  cfg     | input     | cfg_we_i                | page_total
//
// A request that fails without a map read (range, zero run, no pages) goes
// from idle straight to the result state. Allocation reads one 64-bit map
// word per read/evaluate pair until a hit; a run is then marked one word per
// read/write pair. After reset a pass sets all 1024 map words to used with
// in_stall_o held high. Up to two words queue at the input while the back end
// works or the result register is stalled.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [PageW-1:0] target_page_i,
  input  logic [CntW-1:0]  run_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             ok_o,
  output logic [PageW-1:0] first_page_o,
  output logic [CntW-1:0]  used_count_o,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i
);

  ctl_t ctl;
  logic req_valid;
  req_t req;

  bpa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .target_page_i,
    .run_length_i, .ctl_i(ctl), .req_valid_o(req_valid), .req_o(req)
  );

  bpa_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_valid_i(req_valid),
    .req_i(req), .ctl_o(ctl), .out_valid_o, .out_stall_i, .ok_o,
    .first_page_o, .used_count_o
  );

endmodule

// ----- hdl/bpa_checker.sv -----
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg.
module bpa_checker import bpa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             ok_o,
  input logic [PageW-1:0] first_page_o,
  input logic [CntW-1:0]  used_count_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o)
      && $stable(first_page_o) && $stable(used_count_o))
    else $error("stalled result changed");

  // a failed request reports page zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> first_page_o == '0)
    else $error("failed result with nonzero page");

  // map clear pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open during map clear");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .ok_o,
  .first_page_o, .used_count_o
);

// ----- dv/tb_bitmap_page_allocator.sv -----
// Testbench for bitmap_page_allocator: directed table, then random requests over
// several page_total settings, each result checked against an in-bench allocator model.
// Depends on bpa_pkg and the bitmap_page_allocator RTL.
module tb_bitmap_page_allocator import bpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 40_000_000;
  localparam int unsigned UseMax     = 131071;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       kind_i = OP_ALLOC;
  logic [PageW-1:0] target_page_i = '0;
  logic [CntW-1:0]  run_length_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             ok_o;
  logic [PageW-1:0] first_page_o;
  logic [CntW-1:0]  used_count_o;
  logic             cfg_we_i = 1'b0;
  logic [CntW-1:0]  cfg_wdata_i = '0;

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] start;
    logic [CntW-1:0]  used;
  } grant_t;

  typedef struct {
    op_e              op;
    logic [PageW-1:0] target;
    logic [CntW-1:0]  len;
    bit               typed;
    grant_t           grant;
  } row_t;

  bitmap_page_allocator dut (.*);

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // allocator model state
  bit          page_used [NumPages];
  int unsigned fit_cursor;
  int unsigned used_pages;
  int unsigned total_reg;

  grant_t grant_q [$];
  int     errors;
  bit     quiet;
  int unsigned cycles;

  function automatic int unsigned managed_pages();
    return (total_reg > NumPages) ? NumPages : total_reg;
  endfunction

  function automatic void bump_used(int unsigned n);
    int unsigned s;
    s = used_pages + n;
    used_pages = (s > UseMax) ? UseMax : s;
  endfunction

  function automatic void set_total(int unsigned v);
    total_reg  = v & UseMax;
    used_pages = total_reg;
  endfunction

  // compute the grant for one request and update the model
  function automatic grant_t grant_for(op_e op, int unsigned tgt, int unsigned len);
    grant_t      g;
    int unsigned tot, cnt, first, lim;
    bit          hit;
    tot = managed_pages();
    g   = '0;
    hit = 1'b0;
    case (op)
      OP_ALLOC: begin
        lim = (fit_cursor < tot) ? fit_cursor : tot;
        for (int unsigned i = fit_cursor; i < tot && !hit; i++)
          if (!page_used[i]) begin hit = 1'b1; first = i; end
        for (int unsigned i = 0; i < lim && !hit; i++)
          if (!page_used[i]) begin hit = 1'b1; first = i; end
        if (hit) begin
          page_used[first] = 1'b1;
          fit_cursor = first & 16'hFFFF;
          bump_used(1);
          g.ok = 1'b1;
          g.start = first[PageW-1:0];
        end
      end
      OP_RUN: begin
        cnt = 0;
        first = 0;
        if (len != 0) begin
          for (int unsigned i = 1; i < tot && !hit; i++) begin
            if (!page_used[i]) begin
              if (cnt == 0) first = i;
              cnt++;
              if (cnt == len) hit = 1'b1;
            end else begin
              cnt = 0;
            end
          end
        end
        if (hit) begin
          for (int unsigned i = 0; i < len; i++) page_used[first + i] = 1'b1;
          bump_used(len);
          g.ok = 1'b1;
          g.start = first[PageW-1:0];
        end
      end
      OP_FREE: begin
        if (tgt < tot && page_used[tgt]) begin
          page_used[tgt] = 1'b0;
          if (used_pages > 0) used_pages--;
          g.ok = 1'b1;
          g.start = tgt[PageW-1:0];
        end
      end
      default: begin
        if (tgt < tot && !page_used[tgt]) begin
          page_used[tgt] = 1'b1;
          bump_used(1);
          g.ok = 1'b1;
          g.start = tgt[PageW-1:0];
        end
      end
    endcase
    g.used = used_pages[CntW-1:0];
    return g;
  endfunction

  // send one request word; model is updated at acceptance
  task automatic push_req(op_e op, int unsigned tgt, int unsigned len,
                          bit typed = 1'b0, grant_t want = '0);
    grant_t g;
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= op;
    target_page_i <= tgt[PageW-1:0];
    run_length_i  <= len[CntW-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = grant_for(op, tgt, len);
    grant_q.push_back(typed ? want : g);
  endtask

  // let every outstanding result drain before touching the register
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_total(int unsigned v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CntW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    set_total(v);
  endtask

  // random requests, biased toward frees so allocations find room
  task automatic random_reqs(int n);
    int unsigned tot, r, tgt, len;
    op_e op;
    for (int k = 0; k < n; k++) begin
      tot = managed_pages();
      r   = $urandom_range(99);
      tgt = (tot > 0) ? $urandom_range(tot - 1) : 0;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
      if (r < 35)      op = OP_FREE;
      else if (r < 60) op = OP_ALLOC;
      else if (r < 80) op = OP_RUN;
      else if (r < 93) op = OP_RESV;
      else begin
        op  = op_e'($urandom_range(3));
        tgt = $urandom & 16'hFFFF;
        len = ($urandom_range(1) != 0) ? ($urandom & UseMax) : $urandom_range(1);
      end
      push_req(op, tgt, len);
    end
  endtask

  // output stall
  always @(posedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 27);

  // result checker
  always @(posedge clk_i) begin
    grant_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        w = grant_q.pop_front();
        if (ok_o !== w.ok) begin
          $error("ok: expected %0d, got %0d", w.ok, ok_o);
          errors++;
        end
        if (first_page_o !== w.start) begin
          $error("first_page: expected %0d, got %0d", w.start, first_page_o);
          errors++;
        end
        if (used_count_o !== w.used) begin
          $error("used_count: expected %0d, got %0d", w.used, used_count_o);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_bitmap_page_allocator: done, errors");
      $finish;
    end
  end

  row_t rows [$];
  int unsigned totals [$] = '{64, 1, 0, 200, 131071, 100, 65536, 300};

  function automatic row_t mk(op_e op, int unsigned tgt, int unsigned len, bit typed,
                              bit ok, int unsigned st, int unsigned used);
    row_t r;
    r.op = op;
    r.target = tgt;
    r.len = len;
    r.typed = typed;
    r.grant = '{ok: ok, start: st[PageW-1:0], used: used[CntW-1:0]};
    return r;
  endfunction

  initial begin
    errors = 0;
    cycles = 0;
    quiet  = 1'b0;
    for (int i = 0; i < NumPages; i++) page_used[i] = 1'b1;
    fit_cursor = 0;
    set_total(NumPages);

    // directed table; typed rows start from the all-used map after reset
    rows.push_back(mk(OP_ALLOC, 0,     0,      1, 0, 0,     65536));
    rows.push_back(mk(OP_RUN,   0,     0,      1, 0, 0,     65536));
    rows.push_back(mk(OP_RUN,   65535, 131071, 1, 0, 0,     65536));
    rows.push_back(mk(OP_FREE,  65535, 0,      1, 1, 65535, 65535));
    rows.push_back(mk(OP_FREE,  65535, 0,      1, 0, 0,     65535));
    rows.push_back(mk(OP_RESV,  65535, 0,      1, 1, 65535, 65536));
    rows.push_back(mk(OP_RESV,  65535, 131071, 1, 0, 0,     65536));
    rows.push_back(mk(OP_FREE,  0,     0,      1, 1, 0,     65535));
    rows.push_back(mk(OP_ALLOC, 65535, 131071, 1, 1, 0,     65536));
    rows.push_back(mk(OP_FREE,  1,     0,      0, 0, 0,     0));
    rows.push_back(mk(OP_FREE,  2,     0,      0, 0, 0,     0));
    rows.push_back(mk(OP_FREE,  3,     0,      0, 0, 0,     0));
    rows.push_back(mk(OP_RUN,   0,     3,      1, 1, 1,     65536));
    rows.push_back(mk(OP_FREE,  0,     0,      1, 1, 0,     65535));
    rows.push_back(mk(OP_RUN,   0,     1,      1, 0, 0,     65535));
    rows.push_back(mk(OP_ALLOC, 0,     0,      1, 1, 0,     65536));
    rows.push_back(mk(OP_FREE,  40000, 0,      0, 0, 0,     0));
    rows.push_back(mk(OP_FREE,  40001, 0,      0, 0, 0,     0));
    rows.push_back(mk(OP_ALLOC, 0,     0,      0, 0, 0,     0));
    rows.push_back(mk(OP_RUN,   0,     2,      0, 0, 0,     0));
    rows.push_back(mk(OP_RUN,   0,     65536,  0, 0, 0,     0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) push_req(rows[i].op, rows[i].target, rows[i].len,
                               rows[i].typed, rows[i].grant);
    random_reqs(220);

    // one phase per page_total setting
    foreach (totals[p]) begin
      write_total(totals[p]);
      quiet = (p == 3);
      random_reqs((totals[p] >= NumPages) ? 100 : 160);
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("tb_bitmap_page_allocator: done, clean");
    end else begin
      $display("tb_bitmap_page_allocator: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bpa_pkg.sv
hdl/bpa_front.sv
hdl/bpa_back.sv
hdl/bitmap_page_allocator.sv
hdl/bpa_checker.sv
dv/tb_bitmap_page_allocator.sv
